>>> src/lved_pkg.sv
// Shared types, command codes and helpers for the edit-distance engine.
package lved_pkg;

  // Default longest string held on either side
  localparam int LVED_MAX_LEN = 32;
  localparam int SYM_W  = 8;
  localparam int DIST_W = 6;

  // Command codes
  localparam logic [1:0] FN_CLEAR  = 2'd0;
  localparam logic [1:0] FN_APPEND = 2'd1;
  localparam logic [1:0] FN_ANSWER = 2'd2;
  localparam logic [1:0] FN_FINISH = 2'd3;

  typedef struct packed {
    logic [1:0]       func;
    logic [SYM_W-1:0] symbol;
  } lved_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } lved_out_t;

  // Token that walks down the cell row, one cell per cycle
  typedef struct packed {
    logic             vld;  // answer byte wave
    logic             rld;  // reload cost to its index
    logic             fin;  // finish: target cell reports its cost
    logic             ovf;  // overflow flag that goes with a finish
    logic [SYM_W-1:0] sym;
  } lved_wave_t;

  // Clamp a cost to the distance field
  function automatic logic [DIST_W-1:0] sat_dist(input logic [15:0] v);
    logic [DIST_W-1:0] r;
    if (v > 16'((1 << DIST_W) - 1)) begin
      r = '1;
    end else begin
      r = v[DIST_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> src/lved_cell.sv
// One reference position: holds its character and its row cost, passes waves on.
module lved_cell #(
  parameter int IDX = 1,
  parameter int CW  = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lved_pkg::lved_wave_t      wave_in,
  input  logic [CW-1:0]             diag_in,
  input  logic [CW-1:0]             left_cost,
  input  logic [CW-1:0]             ref_len,
  input  logic                      app_we,
  input  logic [lved_pkg::SYM_W-1:0] app_sym,
  output lved_pkg::lved_wave_t      wave_out,
  output logic [CW-1:0]             diag_out,
  output logic [CW-1:0]             cost,
  output logic                      emit
);
  import lved_pkg::*;

  logic [SYM_W-1:0] ch_r;
  logic [CW-1:0]    cost_r, cost_nxt;
  logic [CW-1:0]    diag_r;
  lved_wave_t       wave_r;
  logic [CW-1:0]    m1, m2;

  // Reference character, written when the append lands on this position
  always_ff @(posedge clk) begin
    if (app_we && ref_len == CW'(IDX - 1)) begin
      ch_r <= app_sym;
    end
  end

  // Cost update: reload to index, match takes diagonal, else min of three + 1
  always_comb begin
    m1 = (diag_in < cost_r) ? diag_in : cost_r;
    m2 = (m1 < left_cost) ? m1 : left_cost;
    cost_nxt = cost_r;
    if (wave_in.rld) begin
      cost_nxt = CW'(IDX);
    end else if (wave_in.vld) begin
      if (ch_r == wave_in.sym) begin
        cost_nxt = diag_in;
      end else begin
        cost_nxt = m2 + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r <= CW'(IDX);
      wave_r <= '0;
    end else begin
      cost_r <= cost_nxt;
      wave_r <= wave_in;
    end
  end

  // Old cost becomes the next cell's diagonal
  always_ff @(posedge clk) begin
    diag_r <= cost_r;
  end

  assign wave_out = wave_r;
  assign diag_out = diag_r;
  assign cost     = cost_r;
  assign emit     = wave_in.fin && (ref_len == CW'(IDX));

endmodule

>>> src/levenshtein_edit_distance.sv
// Edit-distance engine: command decode, column zero and the row of cells.
//
// Usage: drive in_item and raise start; a command transfers at a rising edge
// where start is high and busy is low. Commands: clear reference, append a
// reference byte, answer byte, finish answer. Only finish gives a result.
// Each answer byte walks down a row of MAX_LEN cells, one cell per cycle, so
// answer bytes, appends and clears are taken every cycle while busy is low.
// Finish with reference length m > 0: the result appears on out_item with
// out_valid high for one cycle, registered once the finish token reaches cell m;
// busy stays high while the finish token travels down to cell m.
// Finish with an empty reference: result in the next cycle, no busy time.
// The result is shown for exactly one cycle; the receiver cannot stall it.
// Reset (synchronous, rst_n low) empties the reference and the answer and
// reloads every cell with its own index; no clearing pass is needed.
module levenshtein_edit_distance #(
  parameter int MAX_LEN = lved_pkg::LVED_MAX_LEN
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lved_pkg::lved_in_t  in_item,
  output logic                out_valid,
  output lved_pkg::lved_out_t out_item
);
  import lved_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);

  logic            acc;
  logic [CW-1:0]   m_r, m_nxt;
  logic [CW-1:0]   alen_r, alen_nxt;
  logic            ovf_ans_r, ovf_ans_nxt;
  logic            ovf_ref_r, ovf_ref_nxt;
  logic [CW-1:0]   fin_cnt_r, fin_cnt_nxt;
  lved_wave_t      wave0_r, wave0_nxt;
  logic [CW-1:0]   diag0_r, diag0_nxt;
  logic            out_valid_r, out_valid_nxt;
  lved_out_t       out_item_r, out_item_nxt;
  logic            app_we;

  lved_wave_t      wave [0:MAX_LEN-1];
  logic [CW-1:0]   diag [0:MAX_LEN-1];
  logic [CW-1:0]   cost [0:MAX_LEN];
  logic [MAX_LEN:1] emit;
  logic            emit_any;
  logic [CW-1:0]   sel_cost;
  logic            sel_ovf;

  assign acc    = start && !busy;
  assign busy   = (fin_cnt_r != '0);
  assign app_we = acc && (in_item.func == FN_APPEND) && (m_r < CW'(MAX_LEN));

  // Column zero: its cost is the answer length
  assign wave[0]  = wave0_r;
  assign diag[0]  = diag0_r;
  assign cost[0]  = alen_r;

  // Command decode
  always_comb begin
    m_nxt         = m_r;
    alen_nxt      = alen_r;
    ovf_ans_nxt   = ovf_ans_r;
    ovf_ref_nxt   = ovf_ref_r;
    fin_cnt_nxt   = busy ? fin_cnt_r - CW'(1) : fin_cnt_r;
    wave0_nxt     = '0;
    diag0_nxt     = alen_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    if (acc) begin
      wave0_nxt.sym = in_item.symbol;
      unique case (in_item.func)
        FN_CLEAR: begin
          m_nxt         = '0;
          ovf_ref_nxt   = 1'b0;
          alen_nxt      = '0;
          ovf_ans_nxt   = 1'b0;
          wave0_nxt.rld = 1'b1;
        end
        FN_APPEND: begin
          if (m_r < CW'(MAX_LEN)) begin
            m_nxt = m_r + CW'(1);
          end else begin
            ovf_ref_nxt = 1'b1;
          end
          alen_nxt      = '0;
          ovf_ans_nxt   = 1'b0;
          wave0_nxt.rld = 1'b1;
        end
        FN_ANSWER: begin
          if (alen_r == CW'(MAX_LEN)) begin
            ovf_ans_nxt = 1'b1;
          end else begin
            alen_nxt      = alen_r + CW'(1);
            wave0_nxt.vld = 1'b1;
          end
        end
        FN_FINISH: begin
          alen_nxt      = '0;
          ovf_ans_nxt   = 1'b0;
          wave0_nxt.rld = 1'b1;
          if (m_r == '0) begin
            // empty reference: distance is the answer length
            out_valid_nxt         = 1'b1;
            out_item_nxt.distance = sat_dist(16'(alen_r));
            out_item_nxt.overflow = ovf_ans_r | ovf_ref_r;
          end else begin
            wave0_nxt.fin = 1'b1;
            wave0_nxt.ovf = ovf_ans_r | ovf_ref_r;
            fin_cnt_nxt   = m_r;
          end
        end
        default: ;
      endcase
    end
    // Finish token reached cell m
    if (emit_any) begin
      out_valid_nxt         = 1'b1;
      out_item_nxt.distance = sat_dist(16'(sel_cost));
      out_item_nxt.overflow = sel_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r         <= '0;
      alen_r      <= '0;
      ovf_ans_r   <= 1'b0;
      ovf_ref_r   <= 1'b0;
      fin_cnt_r   <= '0;
      wave0_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      m_r         <= m_nxt;
      alen_r      <= alen_nxt;
      ovf_ans_r   <= ovf_ans_nxt;
      ovf_ref_r   <= ovf_ref_nxt;
      fin_cnt_r   <= fin_cnt_nxt;
      wave0_r     <= wave0_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    diag0_r    <= diag0_nxt;
    out_item_r <= out_item_nxt;
  end

  // Row of cells, one per reference position
  for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
    if (j < MAX_LEN) begin : g_mid
      lved_cell #(.IDX(j), .CW(CW)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .wave_in   (wave[j-1]),
        .diag_in   (diag[j-1]),
        .left_cost (cost[j-1]),
        .ref_len   (m_r),
        .app_we    (app_we),
        .app_sym   (in_item.symbol),
        .wave_out  (wave[j]),
        .diag_out  (diag[j]),
        .cost      (cost[j]),
        .emit      (emit[j])
      );
    end else begin : g_last
      lved_cell #(.IDX(j), .CW(CW)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .wave_in   (wave[j-1]),
        .diag_in   (diag[j-1]),
        .left_cost (cost[j-1]),
        .ref_len   (m_r),
        .app_we    (app_we),
        .app_sym   (in_item.symbol),
        .wave_out  (),
        .diag_out  (),
        .cost      (cost[j]),
        .emit      (emit[j])
      );
    end
  end

  // Pick the cost of the reporting cell (at most one reports)
  always_comb begin
    emit_any = 1'b0;
    sel_cost = '0;
    sel_ovf  = 1'b0;
    for (int k = 1; k <= MAX_LEN; k++) begin
      if (emit[k]) begin
        emit_any = 1'b1;
        sel_cost = sel_cost | cost[k];
        sel_ovf  = sel_ovf | wave[k-1].ovf;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> dv/tb_levenshtein_edit_distance.sv
// Self-checking testbench for the edit-distance engine: directed and random commands.
module tb_levenshtein_edit_distance;
  timeunit 1ns;
  timeprecision 1ps;

  import lved_pkg::*;

  localparam int MAX_LEN     = LVED_MAX_LEN;
  localparam int MAX_GAP     = 18;
  localparam int RAND_CMDS   = 1450;
  localparam int DRAIN_CYCLES = 2 * MAX_LEN + 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PRINT_LIMIT = 50;

  typedef struct {
    lved_in_t    cmd;
    int unsigned gap;
  } pending_cmd_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  lved_in_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  lved_out_t out_item;

  levenshtein_edit_distance #(.MAX_LEN(MAX_LEN)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // Predictor: reference string, one DP cost row, answer length, overflow bits
  // ---------------------------------------------------------------------------
  logic [7:0] ref_chars [MAX_LEN];
  int         ref_len = 0;
  int         cost_row [MAX_LEN+1];
  int         ans_len = 0;
  bit         ans_ovf = 1'b0;
  bit         ref_ovf = 1'b0;
  lved_out_t  expected_scores [$];

  // Row back to 0..MAX_LEN, answer restarts
  function automatic void reload_costs();
    for (int j = 0; j <= MAX_LEN; j++) begin
      cost_row[j] = j;
    end
    ans_len = 0;
    ans_ovf = 1'b0;
  endfunction

  function automatic void apply_command(input lved_in_t c);
    int        diag;
    int        above;
    int        best;
    int        d;
    lved_out_t res;
    case (c.func)
      FN_CLEAR: begin
        ref_len = 0;
        ref_ovf = 1'b0;
        reload_costs();
      end
      FN_APPEND: begin
        if (ref_len < MAX_LEN) begin
          ref_chars[ref_len] = c.symbol;
          ref_len++;
        end else begin
          ref_ovf = 1'b1;
        end
        reload_costs();
      end
      FN_ANSWER: begin
        if (ans_len >= MAX_LEN) begin
          ans_ovf = 1'b1;
        end else begin
          ans_len++;
          diag = cost_row[0];
          cost_row[0] = ans_len;
          // left neighbor is already the new row's value
          for (int j = 1; j <= ref_len; j++) begin
            above = cost_row[j];
            if (ref_chars[j-1] == c.symbol) begin
              cost_row[j] = diag;
            end else begin
              best = (diag < above) ? diag : above;
              best = (best < cost_row[j-1]) ? best : cost_row[j-1];
              cost_row[j] = best + 1;
            end
            diag = above;
          end
        end
      end
      FN_FINISH: begin
        d = cost_row[ref_len];
        if (d > (1 << DIST_W) - 1) begin
          d = (1 << DIST_W) - 1;
        end
        res.distance = d[DIST_W-1:0];
        res.overflow = ans_ovf | ref_ovf;
        expected_scores.push_back(res);
        reload_costs();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------------
  int unsigned mismatch_count = 0;

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: pulls commands from the queue, waits each one's gap, holds on busy
  // ---------------------------------------------------------------------------
  pending_cmd_t cmd_queue [$];
  pending_cmd_t staged_cmd;
  bit           staged_vld = 1'b0;
  int unsigned  accepted_count = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      // transfer at this edge
      if (start && !busy) begin
        apply_command(in_item);
        accepted_count++;
      end
      if (!start || !busy) begin
        if (!staged_vld && cmd_queue.size() > 0) begin
          staged_cmd = cmd_queue.pop_front();
          staged_vld = 1'b1;
        end
        if (staged_vld && staged_cmd.gap == 0) begin
          in_item    <= staged_cmd.cmd;
          start      <= 1'b1;
          staged_vld = 1'b0;
        end else begin
          start <= 1'b0;
          if (staged_vld) begin
            staged_cmd.gap--;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lved_out_t want;
    if (rst_n && out_valid) begin
      if (expected_scores.size() == 0) begin
        report_mismatch($sformatf("unexpected result distance=%0d overflow=%0b",
                                  out_item.distance, out_item.overflow));
      end else begin
        want = expected_scores.pop_front();
        if (out_item.distance !== want.distance) begin
          report_mismatch($sformatf("distance got %0d want %0d",
                                    out_item.distance, want.distance));
        end
        if (out_item.overflow !== want.overflow) begin
          report_mismatch($sformatf("overflow got %0b want %0b",
                                    out_item.overflow, want.overflow));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  bit no_gaps = 1'b0;

  task automatic push_cmd(input logic [1:0] fn, input logic [7:0] sym);
    pending_cmd_t p;
    p.cmd.func   = fn;
    p.cmd.symbol = sym;
    // bias toward short gaps, with whole back-to-back stretches
    if (no_gaps || $urandom_range(0, 2) == 0) begin
      p.gap = 0;
    end else begin
      p.gap = $urandom_range(0, MAX_GAP);
    end
    cmd_queue.push_back(p);
  endtask

  // Narrow alphabet makes matches common; wide one exercises every bit
  function automatic logic [7:0] pick_sym(input bit narrow);
    logic [7:0] s;
    if (narrow) begin
      s = 8'h61 + 8'($urandom_range(0, 3));
    end else begin
      s = 8'($urandom_range(0, 255));
    end
    return s;
  endfunction

  initial begin
    string      word_a;
    string      word_b;
    logic [7:0] ref_str [$];
    logic [7:0] ans_str [$];
    bit         narrow;
    int         len;
    int         pick;
    int         pos;
    int         n_answers;
    int         n_edits;
    int unsigned total_cmds;

    // Predictor starts from the reset row 0..MAX_LEN
    reload_costs();

    // Directed: reset state, empty reference, classic pair, restart on append
    push_cmd(FN_FINISH, 8'h00);
    push_cmd(FN_ANSWER, 8'h00);
    push_cmd(FN_ANSWER, 8'hFF);
    push_cmd(FN_FINISH, 8'hFF);
    push_cmd(FN_CLEAR, 8'hFF);
    word_a = "kitten";
    word_b = "sitting";
    for (int i = 0; i < word_a.len(); i++) begin
      push_cmd(FN_APPEND, word_a[i]);
    end
    for (int i = 0; i < word_b.len(); i++) begin
      push_cmd(FN_ANSWER, word_b[i]);
    end
    push_cmd(FN_FINISH, 8'h00);
    push_cmd(FN_FINISH, 8'h55);
    push_cmd(FN_ANSWER, 8'h00);
    push_cmd(FN_APPEND, 8'hFF);
    push_cmd(FN_ANSWER, 8'hFF);
    push_cmd(FN_FINISH, 8'hAA);
    push_cmd(FN_CLEAR, 8'h00);

    // Random: mostly well-formed reference loads and answers, some noise
    total_cmds = cmd_queue.size() + RAND_CMDS;
    while (cmd_queue.size() < total_cmds) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) begin
        narrow = ($urandom_range(0, 1) == 1);
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          len = 0;
        end else if (pick < 15) begin
          len = $urandom_range(1, 8);
        end else if (pick < 18) begin
          len = $urandom_range(9, MAX_LEN);
        end else begin
          len = $urandom_range(MAX_LEN, MAX_LEN + 4);
        end
        push_cmd(FN_CLEAR, pick_sym(1'b0));
        ref_str.delete();
        for (int i = 0; i < len; i++) begin
          ref_str.push_back(pick_sym(narrow));
          push_cmd(FN_APPEND, ref_str[i]);
        end
      end
      n_answers = $urandom_range(1, 4);
      for (int a = 0; a < n_answers; a++) begin
        narrow = ($urandom_range(0, 2) != 0);
        pick = $urandom_range(0, 9);
        ans_str.delete();
        if (pick < 6) begin
          // edited copy of the reference
          ans_str = ref_str;
          n_edits = $urandom_range(0, 3);
          for (int e = 0; e < n_edits; e++) begin
            pos = $urandom_range(0, ans_str.size());
            case ($urandom_range(0, 2))
              0: ans_str.insert(pos, pick_sym(narrow));
              1: if (pos < ans_str.size()) ans_str.delete(pos);
              default: if (pos < ans_str.size()) ans_str[pos] = pick_sym(narrow);
            endcase
          end
        end else if (pick < 8) begin
          len = $urandom_range(0, 8);
          for (int i = 0; i < len; i++) begin
            ans_str.push_back(pick_sym(narrow));
          end
        end else if (pick == 8) begin
          // long answer, often past the limit
          len = $urandom_range(MAX_LEN - 2, MAX_LEN + 4);
          for (int i = 0; i < len; i++) begin
            ans_str.push_back(pick_sym(narrow));
          end
        end
        for (int i = 0; i < ans_str.size(); i++) begin
          // occasional stray command breaks the sequence
          if ($urandom_range(0, 39) == 0) begin
            push_cmd(2'($urandom_range(0, 3)), pick_sym(1'b0));
          end
          push_cmd(FN_ANSWER, ans_str[i]);
        end
        push_cmd(FN_FINISH, pick_sym(1'b0));
      end
      if ($urandom_range(0, 9) == 0) begin
        push_cmd(2'($urandom_range(0, 3)), pick_sym(1'b0));
      end
    end
    total_cmds = cmd_queue.size();
    no_gaps = 1'b0;

    // Reset, then let the driver run
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < total_cmds) @(posedge clk);
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hang guard
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("TIMEOUT after %0d cycles, %0d results still expected",
             cycle_count, expected_scores.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
src/lved_pkg.sv
src/lved_cell.sv
src/levenshtein_edit_distance.sv
dv/tb_levenshtein_edit_distance.sv
